>>> rtl/els_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// els_pkg
// Shared types and constants of the learning switch forwarding core.
// ----------------------------------------------------------------------------
package els_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned PORT_W    = 4;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned GROUP_BIT = 40;

  localparam logic [OP_W-1:0] OP_FRAME      = 2'd0;
  localparam logic [OP_W-1:0] OP_CONNECT    = 2'd1;
  localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd2;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0]  REG_HUB_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic clear_wr;
    logic scan_rd;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic addr_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/els_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// els_if
// Valid/ready channels carrying frame items in and forwarding results out.
// ----------------------------------------------------------------------------
interface els_in_if;
  logic                       valid;
  logic                       ready;
  logic [els_pkg::OP_W-1:0]   opcode;
  logic [els_pkg::PORT_W-1:0] port_index;
  logic [els_pkg::MAC_W-1:0]  dest_mac;
  logic [els_pkg::MAC_W-1:0]  src_mac;

  modport source (output valid, opcode, port_index, dest_mac, src_mac, input ready);
  modport sink (input valid, opcode, port_index, dest_mac, src_mac, output ready);
endinterface

interface els_out_if;
  logic                       valid;
  logic                       ready;
  logic [els_pkg::MASK_W-1:0] egress_mask;
  logic                       flooded;
  logic                       dest_unknown;
  logic                       ingress_unknown;
  logic                       source_learned;
  logic                       table_full;

  modport source (output valid, egress_mask, flooded, dest_unknown, ingress_unknown,
                  source_learned, table_full, input ready);
  modport sink (input valid, egress_mask, flooded, dest_unknown, ingress_unknown,
                source_learned, table_full, output ready);
endinterface
`default_nettype wire

>>> rtl/ethernet_learning_switch_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_learning_switch_core
// Forwarding decision of a learning Ethernet switch with an address table.
// ----------------------------------------------------------------------------
// One item in flight at a time. A frame or disconnect beat walks the address
// table once through its single read port, one entry per cycle, then passes a
// drain state and commits in FINISH once the result slot is free, before the
// next beat is taken; connect beats and unused opcodes go straight to FINISH.
// After reset the table is cleared one entry per cycle, before the first beat
// is accepted; the hub_mode register at address 0 can be written during that
// time.
module ethernet_learning_switch_core #(
  parameter int unsigned NUM_PORTS     = 16,
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  els_in_if.sink                             in_if,
  els_out_if.source                          out_if,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [els_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [els_pkg::PDATA_W-1:0]   pwdata,
  output logic [els_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  logic             hub_mode_q;
  logic             cfg_sel;
  els_pkg::ctrl_t   ctrl;
  els_pkg::status_t status;
  logic             in_ready;

  assign cfg_sel = (paddr[els_pkg::PADDR_W-1] == els_pkg::REG_HUB_MODE);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? els_pkg::PDATA_W'(hub_mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hub_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && cfg_sel) begin
      hub_mode_q <= pwdata[0];
    end
  end

  assign in_if.ready = in_ready;

  els_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_op_i    (in_if.opcode),
    .in_ready_o (in_ready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  els_datapath #(
    .NUM_PORTS     (NUM_PORTS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .status_o          (status),
    .hub_mode_i        (hub_mode_q),
    .in_op_i           (in_if.opcode),
    .in_port_i         (in_if.port_index),
    .in_dst_i          (in_if.dest_mac),
    .in_src_i          (in_if.src_mac),
    .out_ready_i       (out_if.ready),
    .out_valid_o       (out_if.valid),
    .egress_mask_o     (out_if.egress_mask),
    .flooded_o         (out_if.flooded),
    .dest_unknown_o    (out_if.dest_unknown),
    .ingress_unknown_o (out_if.ingress_unknown),
    .source_learned_o  (out_if.source_learned),
    .table_full_o      (out_if.table_full)
  );

endmodule
`default_nettype wire

>>> rtl/els_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// els_ctrl
// Sequencer: table clear after reset, item intake, table scan, commit.
// ----------------------------------------------------------------------------
module els_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [els_pkg::OP_W-1:0] in_op_i,
  output logic                          in_ready_o,
  input  wire els_pkg::status_t         status_i,
  output els_pkg::ctrl_t                ctrl_o
);

  els_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= els_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      els_pkg::ST_CLEAR: begin
        ctrl_o.clear_wr = 1'b1;
        if (status_i.addr_last) begin
          state_d = els_pkg::ST_IDLE;
        end
      end
      els_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          if (in_op_i == els_pkg::OP_FRAME || in_op_i == els_pkg::OP_DISCONNECT) begin
            state_d = els_pkg::ST_SCAN;
          end else begin
            state_d = els_pkg::ST_FINISH;
          end
        end
      end
      els_pkg::ST_SCAN: begin
        ctrl_o.scan_rd = 1'b1;
        if (status_i.addr_last) begin
          state_d = els_pkg::ST_DRAIN;
        end
      end
      els_pkg::ST_DRAIN: begin
        state_d = els_pkg::ST_FINISH;
      end
      els_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          ctrl_o.finish = 1'b1;
          state_d       = els_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = els_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/els_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// els_datapath
// Address table memory, port state, search registers, decision and result.
// ----------------------------------------------------------------------------
module els_datapath #(
  parameter int unsigned NUM_PORTS     = 16,
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire els_pkg::ctrl_t               ctrl_i,
  output els_pkg::status_t                  status_o,
  input  wire logic                         hub_mode_i,
  input  wire logic [els_pkg::OP_W-1:0]     in_op_i,
  input  wire logic [els_pkg::PORT_W-1:0]   in_port_i,
  input  wire logic [els_pkg::MAC_W-1:0]    in_dst_i,
  input  wire logic [els_pkg::MAC_W-1:0]    in_src_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [els_pkg::MASK_W-1:0]        egress_mask_o,
  output logic                              flooded_o,
  output logic                              dest_unknown_o,
  output logic                              ingress_unknown_o,
  output logic                              source_learned_o,
  output logic                              table_full_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned WORD_W = 1 + els_pkg::PORT_W + els_pkg::MAC_W;
  localparam int unsigned ACT_W  = (NUM_PORTS > els_pkg::MASK_W) ? NUM_PORTS
                                                                  : els_pkg::MASK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // table memory: {valid, port, mac}
  logic [WORD_W-1:0] mem [TABLE_ENTRIES];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [IDX_W-1:0] addr_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic [els_pkg::OP_W-1:0]   op_q;
  logic [els_pkg::PORT_W-1:0] port_q;
  logic [els_pkg::MAC_W-1:0]  dst_q, src_q, key_q;

  logic [NUM_PORTS-1:0]      active_q, learned_q;
  logic [els_pkg::MAC_W-1:0] last_mac_q [NUM_PORTS];

  logic                       a_hit_q, f_hit_q, b_hit_q;
  logic [IDX_W-1:0]           a_idx_q, f_idx_q;
  logic [els_pkg::PORT_W-1:0] a_port_q, b_port_q;

  logic                       out_valid_q;
  logic [els_pkg::MASK_W-1:0] mask_q;
  logic                       flooded_q, dunk_q, iunk_q, learn_q, full_q;

  logic                       e_vld;
  logic [els_pkg::PORT_W-1:0] e_port;
  logic [els_pkg::MAC_W-1:0]  e_mac;

  logic [PIDX_W-1:0]          in_pidx, pidx, tidx;
  logic                       in_range, ing_ok, is_frame;
  logic                       learn_try, move, insert, full, learned, same_mac;
  logic                       found, hit, t_range, dst_group, flood;
  logic [els_pkg::PORT_W-1:0] tport;
  logic [IDX_W-1:0]           widx;
  logic                       disc_ok, conn_ok, inval;
  logic [ACT_W-1:0]           act_ext;
  logic [els_pkg::MASK_W-1:0] ing_bit, mask;

  assign status_o.addr_last = (addr_q == LAST_IDX);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // scan / clear address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.scan_rd;
      if (ctrl_i.load) begin
        addr_q <= '0;
      end else if (ctrl_i.clear_wr || ctrl_i.scan_rd) begin
        addr_q <= (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (ctrl_i.scan_rd) begin
      rdata_q <= mem[addr_q];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // item capture
  assign in_pidx = PIDX_W'(in_port_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q   <= in_op_i;
      port_q <= in_port_i;
      dst_q  <= in_dst_i;
      src_q  <= in_src_i;
      key_q  <= (in_op_i == els_pkg::OP_DISCONNECT) ? last_mac_q[in_pidx] : in_src_i;
    end
  end

  // search: lowest matching index for key, dst and free slot
  assign e_vld  = rdata_q[WORD_W-1];
  assign e_port = rdata_q[WORD_W-2 -: els_pkg::PORT_W];
  assign e_mac  = rdata_q[els_pkg::MAC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_hit_q <= 1'b0;
      f_hit_q <= 1'b0;
      b_hit_q <= 1'b0;
    end else if (ctrl_i.load) begin
      a_hit_q <= 1'b0;
      f_hit_q <= 1'b0;
      b_hit_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (e_vld && e_mac == key_q && !a_hit_q) begin
        a_hit_q <= 1'b1;
      end
      if (!e_vld && !f_hit_q) begin
        f_hit_q <= 1'b1;
      end
      if (e_vld && e_mac == dst_q && !b_hit_q) begin
        b_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (e_vld && e_mac == key_q && !a_hit_q) begin
        a_idx_q  <= rd_idx_q;
        a_port_q <= e_port;
      end
      if (!e_vld && !f_hit_q) begin
        f_idx_q <= rd_idx_q;
      end
      if (e_vld && e_mac == dst_q && !b_hit_q) begin
        b_port_q <= e_port;
      end
    end
  end

  // decision
  always_comb begin
    pidx      = PIDX_W'(port_q);
    in_range  = int'(port_q) < NUM_PORTS;
    ing_ok    = in_range && active_q[pidx];
    is_frame  = (op_q == els_pkg::OP_FRAME);
    learn_try = is_frame && ing_ok && !src_q[els_pkg::GROUP_BIT];
    move      = learn_try && a_hit_q && (a_port_q != port_q);
    insert    = learn_try && !a_hit_q && f_hit_q;
    full      = learn_try && !a_hit_q && !f_hit_q;
    learned   = move || insert;
    widx      = move ? a_idx_q : f_idx_q;

    // a source just learned is visible to the destination lookup
    same_mac  = learned && (dst_q == src_q);
    found     = b_hit_q || same_mac;
    tport     = same_mac ? port_q : b_port_q;
    tidx      = PIDX_W'(tport);
    t_range   = int'(tport) < NUM_PORTS;
    hit       = found && t_range && active_q[tidx];
    dst_group = dst_q[els_pkg::GROUP_BIT];
    flood     = !hit || dst_group || hub_mode_i;

    act_ext   = ACT_W'(active_q);
    ing_bit   = ing_ok ? (els_pkg::MASK_W'(1) << port_q) : '0;
    if (!is_frame) begin
      mask = '0;
    end else if (flood) begin
      mask = act_ext[els_pkg::MASK_W-1:0] & ~ing_bit;
    end else begin
      mask = els_pkg::MASK_W'(1) << tport;
    end

    disc_ok = (op_q == els_pkg::OP_DISCONNECT) && in_range && active_q[pidx];
    conn_ok = (op_q == els_pkg::OP_CONNECT) && in_range && !active_q[pidx];
    inval   = disc_ok && learned_q[pidx] && a_hit_q && (a_port_q == port_q);

    mem_we    = ctrl_i.clear_wr || (ctrl_i.finish && (learned || inval));
    if (ctrl_i.clear_wr) begin
      mem_waddr = addr_q;
      mem_wdata = '0;
    end else if (inval) begin
      mem_waddr = a_idx_q;
      mem_wdata = '0;
    end else begin
      mem_waddr = widx;
      mem_wdata = {1'b1, port_q, src_q};
    end
  end

  // port state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      learned_q <= '0;
    end else if (ctrl_i.finish) begin
      if (conn_ok || disc_ok) begin
        active_q[pidx]  <= conn_ok;
        learned_q[pidx] <= 1'b0;
      end else if (learned) begin
        learned_q[pidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish && learned) begin
      last_mac_q[pidx] <= src_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      mask_q    <= mask;
      flooded_q <= is_frame && flood;
      dunk_q    <= is_frame && !hit && !dst_group;
      iunk_q    <= is_frame && !ing_ok;
      learn_q   <= learned;
      full_q    <= full;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign egress_mask_o     = mask_q;
  assign flooded_o         = flooded_q;
  assign dest_unknown_o    = dunk_q;
  assign ingress_unknown_o = iunk_q;
  assign source_learned_o  = learn_q;
  assign table_full_o      = full_q;

endmodule
`default_nettype wire

>>> sim/ethernet_learning_switch_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_learning_switch_core_test
// Self-checking bench for the learning switch forwarding core. A short table
// of directed beats walks learning, moves, closed-port hits and port open and
// close, then random traffic runs in phases with hub mode on and off. Random
// phases use a small address pool first and fresh addresses later, so that the
// table fills up. Each result is checked against a predictor or its typed row.
// ----------------------------------------------------------------------------
module ethernet_learning_switch_core_test;
  import els_pkg::*;

  localparam int PORTS         = 16;
  localparam int TABLE_ENTRIES = 64;
  localparam int POOL          = 40;
  localparam int LONG_HOLD     = 300;

  localparam logic [OP_W-1:0]  OP_UNUSED  = 2'd3;
  localparam logic [MAC_W-1:0] GROUP_MASK = MAC_W'(1) << GROUP_BIT;
  localparam logic [MAC_W-1:0] MAC_A      = 48'h02_00_00_00_00_0A;
  localparam logic [MAC_W-1:0] MAC_B      = 48'h02_00_00_00_00_0B;
  localparam logic [MAC_W-1:0] MAC_C      = 48'h02_00_00_00_00_0C;
  localparam logic [MAC_W-1:0] MAC_D      = 48'h02_00_00_00_00_0D;
  localparam logic [MAC_W-1:0] MAC_E      = 48'h02_00_00_00_00_0E;
  localparam logic [MAC_W-1:0] MAC_GRP    = 48'h01_00_5E_00_00_01;
  localparam logic [MAC_W-1:0] MAC_HIGH   = 48'hFE_FF_FF_FF_FF_FF;

  typedef struct packed {
    logic [MASK_W-1:0] egress_mask;
    logic              flooded;
    logic              dest_unknown;
    logic              ingress_unknown;
    logic              source_learned;
    logic              table_full;
  } fwd_decision_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  dst;
    logic [MAC_W-1:0]  src;
    logic              typed;
    fwd_decision_t     want;
  } stim_row_t;

  localparam fwd_decision_t NO_DEC = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  els_in_if  frame_ch ();
  els_out_if decision_ch ();

  ethernet_learning_switch_core #(
    .NUM_PORTS    (PORTS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (frame_ch),
    .out_if (decision_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  bit                hub_on;
  bit                slot_used       [TABLE_ENTRIES];
  logic [MAC_W-1:0]  slot_mac        [TABLE_ENTRIES];
  logic [PORT_W-1:0] slot_port       [TABLE_ENTRIES];
  bit                port_on         [PORTS];
  bit                port_owns       [PORTS];
  logic [MAC_W-1:0]  port_recent_mac [PORTS];

  fwd_decision_t     decision_q [$];
  logic [MAC_W-1:0]  mac_pool   [POOL];
  logic [MAC_W-1:0]  seen_srcs  [$];
  stim_row_t         directed_rows [$];

  int unsigned errors;
  int unsigned beats_sent, beats_seen;
  int unsigned n_flood, n_unicast, n_learned, n_full, n_orphan, long_holds;
  int unsigned tx_left, rx_left;
  bit          tx_calm, rx_calm;
  bit          long_hold_req;

  function automatic int lookup_slot(input logic [MAC_W-1:0] mac);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i] && slot_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic fwd_decision_t forward_decide(input logic [OP_W-1:0] op,
                                                   input logic [PORT_W-1:0] port,
                                                   input logic [MAC_W-1:0] dst,
                                                   input logic [MAC_W-1:0] src);
    fwd_decision_t d;
    int            k;
    int            tport;
    bit            in_range;
    bit            ing_ok;
    bit            hit;
    d        = '0;
    in_range = int'(port) < PORTS;
    hit      = 1'b0;
    tport    = 0;
    case (op)
      OP_CONNECT: begin
        if (in_range && !port_on[port]) begin
          port_on[port]   = 1'b1;
          port_owns[port] = 1'b0;
        end
      end
      OP_DISCONNECT: begin
        if (in_range && port_on[port]) begin
          if (port_owns[port]) begin
            k = lookup_slot(port_recent_mac[port]);
            if (k >= 0 && slot_port[k] == port) slot_used[k] = 1'b0;
          end
          port_on[port]   = 1'b0;
          port_owns[port] = 1'b0;
        end
      end
      OP_FRAME: begin
        ing_ok = in_range && port_on[port];
        if (!ing_ok) begin
          d.ingress_unknown = 1'b1;
        end else if (!src[GROUP_BIT]) begin
          k = lookup_slot(src);
          if (k >= 0) begin
            if (slot_port[k] != port) begin
              slot_port[k]          = port;
              port_recent_mac[port] = src;
              port_owns[port]       = 1'b1;
              d.source_learned      = 1'b1;
            end
          end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
              if (!slot_used[i]) begin
                k = i;
                break;
              end
            if (k < 0) begin
              d.table_full = 1'b1;
            end else begin
              slot_used[k]          = 1'b1;
              slot_mac[k]           = src;
              slot_port[k]          = port;
              port_recent_mac[port] = src;
              port_owns[port]       = 1'b1;
              d.source_learned      = 1'b1;
            end
          end
        end
        k = lookup_slot(dst);
        if (k >= 0 && int'(slot_port[k]) < PORTS && port_on[slot_port[k]]) begin
          hit   = 1'b1;
          tport = slot_port[k];
        end
        if (!hit && !dst[GROUP_BIT]) d.dest_unknown = 1'b1;
        if (!hit || dst[GROUP_BIT] || hub_on) begin
          d.flooded = 1'b1;
          for (int i = 0; i < PORTS && i < int'(MASK_W); i++)
            if (port_on[i] && !(ing_ok && i == int'(port))) d.egress_mask[i] = 1'b1;
        end else if (tport < int'(MASK_W)) begin
          d.egress_mask[tport] = 1'b1;
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  // per-beat wait, with runs of back-to-back beats mixed in
  function automatic int unsigned pick_wait(inout int unsigned left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      left = $urandom_range(4, 30);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic check_field(input string name, input logic [MASK_W-1:0] want,
                             input logic [MASK_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // called at a rising edge; returns at the edge that accepted the beat
  task automatic send_beat(input stim_row_t row);
    int unsigned   gap;
    fwd_decision_t predicted;
    gap = pick_wait(tx_left, tx_calm);
    if (gap != 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_ch.valid      <= 1'b1;
    frame_ch.opcode     <= row.op;
    frame_ch.port_index <= row.port;
    frame_ch.dest_mac   <= row.dst;
    frame_ch.src_mac    <= row.src;
    @(posedge clk_i);
    while (frame_ch.ready !== 1'b1) @(posedge clk_i);
    predicted = forward_decide(row.op, row.port, row.dst, row.src);
    decision_q.push_back(row.typed ? row.want : predicted);
    beats_sent++;
  endtask

  task automatic settle();
    frame_ch.valid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic hub);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_HUB_MODE);
    pwdata  <= PDATA_W'(hub);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    hub_on   = hub;
  endtask

  task automatic run_phase(input logic hub, input int unsigned fresh_pct,
                           input int unsigned count, input int unsigned hold_at);
    stim_row_t   row;
    int unsigned pick;
    int unsigned p;
    settle();
    apb_write(hub);
    for (int unsigned n = 0; n < count; n++) begin
      row  = '0;
      pick = $urandom_range(0, 99);
      row.op = (pick < 80) ? OP_FRAME : (pick < 89) ? OP_CONNECT :
               (pick < 97) ? OP_DISCONNECT : OP_UNUSED;
      row.port = PORT_W'($urandom_range(0, PORTS - 1));
      // frames and closes mostly land on open ports
      if (row.op != OP_CONNECT && $urandom_range(0, 99) < 85)
        for (int j = 0; j < PORTS; j++) begin
          p = (int'(row.port) + j) % PORTS;
          if (port_on[p]) begin
            row.port = PORT_W'(p);
            break;
          end
        end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        row.src = random_mac() | GROUP_MASK;
      end else if (pick < 8 + fresh_pct) begin
        row.src = random_mac() & ~GROUP_MASK;
        seen_srcs.push_back(row.src);
        if (seen_srcs.size() > 32) void'(seen_srcs.pop_front());
      end else begin
        row.src = mac_pool[$urandom_range(0, POOL - 1)];
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) row.dst = random_mac() | GROUP_MASK;
      else if (pick < 15) row.dst = '1;
      else if (pick < 25) row.dst = random_mac();
      else if (pick < 45 && seen_srcs.size() != 0)
        row.dst = seen_srcs[$urandom_range(0, seen_srcs.size() - 1)];
      else row.dst = mac_pool[$urandom_range(0, POOL - 1)];
      if (n == hold_at) long_hold_req = 1'b1;
      send_beat(row);
    end
  endtask

  initial begin : result_sink
    int unsigned   stall;
    fwd_decision_t got;
    fwd_decision_t want;
    decision_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        decision_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
        long_holds++;
      end else begin
        stall = pick_wait(rx_left, rx_calm);
        if (stall != 0) begin
          decision_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      decision_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (decision_ch.valid !== 1'b1) @(posedge clk_i);
      got = '{decision_ch.egress_mask, decision_ch.flooded, decision_ch.dest_unknown,
              decision_ch.ingress_unknown, decision_ch.source_learned,
              decision_ch.table_full};
      beats_seen++;
      if (decision_q.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing expected, actual %p", $time, got);
      end else begin
        want = decision_q.pop_front();
        check_field("egress_mask", want.egress_mask, got.egress_mask);
        check_field("flooded", MASK_W'(want.flooded), MASK_W'(got.flooded));
        check_field("dest_unknown", MASK_W'(want.dest_unknown), MASK_W'(got.dest_unknown));
        check_field("ingress_unknown", MASK_W'(want.ingress_unknown),
                    MASK_W'(got.ingress_unknown));
        check_field("source_learned", MASK_W'(want.source_learned),
                    MASK_W'(got.source_learned));
        check_field("table_full", MASK_W'(want.table_full), MASK_W'(got.table_full));
        n_flood   += want.flooded;
        n_unicast += (!want.flooded && want.egress_mask != 0);
        n_learned += want.source_learned;
        n_full    += want.table_full;
        n_orphan  += want.ingress_unknown;
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    frame_ch.valid      = 1'b0;
    frame_ch.opcode     = OP_FRAME;
    frame_ch.port_index = '0;
    frame_ch.dest_mac   = '0;
    frame_ch.src_mac    = '0;
    for (int i = 0; i < POOL; i++) mac_pool[i] = random_mac() & ~GROUP_MASK;

    // op, port, dst, src, typed, expected
    directed_rows = '{
      '{OP_FRAME,      4'd0,  '1,       '0,       1'b1, '{16'h0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{OP_UNUSED,     4'd15, '1,       '1,       1'b1, NO_DEC},
      '{OP_CONNECT,    4'd0,  '0,       '0,       1'b1, NO_DEC},
      '{OP_CONNECT,    4'd1,  '0,       '0,       1'b1, NO_DEC},
      '{OP_CONNECT,    4'd15, '0,       '0,       1'b1, NO_DEC},
      '{OP_CONNECT,    4'd15, '0,       '0,       1'b1, NO_DEC},
      '{OP_FRAME,      4'd0,  MAC_B,    MAC_A,    1'b0, NO_DEC},
      '{OP_FRAME,      4'd1,  MAC_A,    MAC_B,    1'b0, NO_DEC},
      '{OP_FRAME,      4'd15, MAC_B,    MAC_A,    1'b0, NO_DEC},
      '{OP_FRAME,      4'd1,  MAC_B,    MAC_B,    1'b0, NO_DEC},
      '{OP_FRAME,      4'd0,  MAC_A,    MAC_GRP,  1'b0, NO_DEC},
      '{OP_FRAME,      4'd1,  MAC_GRP,  MAC_C,    1'b0, NO_DEC},
      '{OP_FRAME,      4'd1,  '0,       MAC_D,    1'b0, NO_DEC},
      '{OP_DISCONNECT, 4'd15, '0,       '0,       1'b1, NO_DEC},
      '{OP_FRAME,      4'd0,  MAC_A,    '0,       1'b0, NO_DEC},
      '{OP_DISCONNECT, 4'd1,  '0,       '0,       1'b1, NO_DEC},
      '{OP_FRAME,      4'd0,  MAC_C,    MAC_HIGH, 1'b0, NO_DEC},
      '{OP_CONNECT,    4'd2,  '0,       '0,       1'b1, NO_DEC},
      '{OP_FRAME,      4'd2,  MAC_HIGH, MAC_C,    1'b0, NO_DEC},
      '{OP_DISCONNECT, 4'd3,  '0,       '0,       1'b1, NO_DEC},
      '{OP_FRAME,      4'd7,  MAC_C,    MAC_E,    1'b0, NO_DEC},
      '{OP_FRAME,      4'd2,  MAC_B,    MAC_C,    1'b0, NO_DEC},
      '{OP_CONNECT,    4'd1,  '0,       '0,       1'b1, NO_DEC},
      '{OP_FRAME,      4'd1,  MAC_B,    '0,       1'b0, NO_DEC}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_write(1'b0);
    foreach (directed_rows[r]) send_beat(directed_rows[r]);

    // pool addresses first, then fresh ones until the table runs full
    run_phase(1'b1, 5, 300, '1);
    run_phase(1'b0, 0, 320, 120);
    run_phase(1'b0, 60, 320, 150);
    run_phase(1'b1, 30, 310, '1);
    settle();
    repeat (2 * TABLE_ENTRIES) @(posedge clk_i);

    $display("sent %0d beats, checked %0d results, %0d long output stalls",
             beats_sent, beats_seen, long_holds);
    $display("flooded %0d, unicast %0d, learned %0d, table full %0d, unknown ingress %0d",
             n_flood, n_unicast, n_learned, n_full, n_orphan);
    if (errors == 0) begin
      $display("ethernet_learning_switch_core_test OK");
    end else begin
      $display("ethernet_learning_switch_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("run timed out with %0d results outstanding", decision_q.size());
    $display("ethernet_learning_switch_core_test NOT OK");
    $finish;
  end

endmodule
